// ===== design/ccg_pkg.sv =====
// Shared types, constants and the control program of the coherence candidate generator.
`default_nettype none

package ccg_pkg;

   localparam int DIM_W = 9;
   localparam int DIM_MAX = 511;
   localparam int ROW_W = 8;
   localparam int COL_W = 8;
   localparam int MAP_W = 17;
   localparam int IDX_W = 16;
   localparam int SLOT_W = 4;
   localparam int LIMIT_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;
   localparam int BIT_CNT_W = $clog2(ROW_W);
   localparam int NEIGHBORS = 12;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NEIGHBORS - 1);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = 17'h10000;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_LIMIT = 2'd3;

   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   typedef logic [3:0] cmd_type;
   localparam cmd_type CMD_NOP = 4'd0;
   localparam cmd_type CMD_CLEAR = 4'd1;
   localparam cmd_type CMD_ACCEPT = 4'd2;
   localparam cmd_type CMD_MOD_STEP = 4'd3;
   localparam cmd_type CMD_NBR = 4'd4;
   localparam cmd_type CMD_ADDR = 4'd5;
   localparam cmd_type CMD_READ = 4'd6;
   localparam cmd_type CMD_CAND = 4'd7;
   localparam cmd_type CMD_EMIT = 4'd8;
   localparam cmd_type CMD_SLOT_INC = 4'd9;
   localparam cmd_type CMD_WRITE = 4'd10;

   typedef logic [2:0] cond_type;
   localparam cond_type COND_NONE = 3'd0;
   localparam cond_type COND_ALWAYS = 3'd1;
   localparam cond_type COND_NO_REQ = 3'd2;
   localparam cond_type COND_IS_WRITE = 3'd3;
   localparam cond_type COND_BITS_LEFT = 3'd4;
   localparam cond_type COND_OUT_BUSY = 3'd5;
   localparam cond_type COND_SLOT_MORE = 3'd6;
   localparam cond_type COND_CLR_MORE = 3'd7;

   localparam upc_type S_CLEAR = 4'd0;
   localparam upc_type S_FETCH = 4'd1;
   localparam upc_type S_DECODE = 4'd2;
   localparam upc_type S_MOD = 4'd3;
   localparam upc_type S_NBR = 4'd4;
   localparam upc_type S_ADDR = 4'd5;
   localparam upc_type S_READ = 4'd6;
   localparam upc_type S_CAND = 4'd7;
   localparam upc_type S_EMIT = 4'd8;
   localparam upc_type S_LOOP = 4'd9;
   localparam upc_type S_DONE = 4'd10;
   localparam upc_type S_WR_ADDR = 4'd11;
   localparam upc_type S_WR_MEM = 4'd12;

   typedef struct packed {
      cmd_type cmd;
      cond_type cond;
      upc_type target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic is_write;
      logic bits_left;
      logic out_busy;
      logic slot_more;
      logic clr_more;
   } stat_type;

   function automatic ctrl_type cword(cmd_type cmd, cond_type cond, upc_type target);
      ctrl_type w;
      w.cmd = cmd;
      w.cond = cond;
      w.target = target;
      return w;
   endfunction

   function automatic ctrl_type ucode(upc_type step);
      ctrl_type w;
      unique case (step)
         S_CLEAR: w = cword(CMD_CLEAR, COND_CLR_MORE, S_CLEAR);
         S_FETCH: w = cword(CMD_ACCEPT, COND_NO_REQ, S_FETCH);
         S_DECODE: w = cword(CMD_NOP, COND_IS_WRITE, S_WR_ADDR);
         S_MOD: w = cword(CMD_MOD_STEP, COND_BITS_LEFT, S_MOD);
         S_NBR: w = cword(CMD_NBR, COND_NONE, S_NBR);
         S_ADDR: w = cword(CMD_ADDR, COND_NONE, S_ADDR);
         S_READ: w = cword(CMD_READ, COND_NONE, S_READ);
         S_CAND: w = cword(CMD_CAND, COND_NONE, S_CAND);
         S_EMIT: w = cword(CMD_EMIT, COND_OUT_BUSY, S_EMIT);
         S_LOOP: w = cword(CMD_SLOT_INC, COND_SLOT_MORE, S_NBR);
         S_DONE: w = cword(CMD_NOP, COND_ALWAYS, S_FETCH);
         S_WR_ADDR: w = cword(CMD_ADDR, COND_NONE, S_WR_ADDR);
         S_WR_MEM: w = cword(CMD_WRITE, COND_ALWAYS, S_FETCH);
         default: w = cword(CMD_NOP, COND_ALWAYS, S_FETCH);
      endcase
      return w;
   endfunction

   // Rows above the pixel for each neighbor slot.
   function automatic logic [1:0] slot_rows_up(logic [SLOT_W-1:0] slot);
      logic [1:0] r;
      if (slot < 4'd5) begin
         r = 2'd2;
      end else if (slot < 4'd10) begin
         r = 2'd1;
      end else begin
         r = 2'd0;
      end
      return r;
   endfunction

   // Column offset for each neighbor slot.
   function automatic logic signed [2:0] slot_col_off(logic [SLOT_W-1:0] slot);
      logic signed [2:0] c;
      unique case (slot)
         4'd0, 4'd5, 4'd10: c = -3'sd2;
         4'd1, 4'd6, 4'd11: c = -3'sd1;
         4'd2, 4'd7: c = 3'sd0;
         4'd3, 4'd8: c = 3'sd1;
         4'd4, 4'd9: c = 3'sd2;
         default: c = 3'sd0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/ccg_req_if.sv =====
// Request channel interface carrying map writes and candidate queries.
`default_nettype none

interface ccg_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic [ccg_pkg::ROW_W-1:0] row;
   logic [ccg_pkg::COL_W-1:0] col;
   logic signed [ccg_pkg::MAP_W-1:0] map_value;

   modport source (output valid, output opcode, output row, output col, output map_value,
      input ready);
   modport sink (input valid, input opcode, input row, input col, input map_value,
      output ready);
endinterface

`default_nettype wire

// ===== design/ccg_rsp_if.sv =====
// Response channel interface carrying one candidate per transfer.
`default_nettype none

interface ccg_rsp_if;
   logic valid;
   logic ready;
   logic candidate_valid;
   logic [ccg_pkg::IDX_W-1:0] candidate_index;
   logic [ccg_pkg::SLOT_W-1:0] neighbor_slot;
   logic is_last;
   logic [ccg_pkg::SLOT_W-1:0] valid_count;

   modport source (output valid, output candidate_valid, output candidate_index,
      output neighbor_slot, output is_last, output valid_count, input ready);
   modport sink (input valid, input candidate_valid, input candidate_index,
      input neighbor_slot, input is_last, input valid_count, output ready);
endinterface

`default_nettype wire

// ===== design/ccg_csr_if.sv =====
// Configuration write channel interface.
`default_nettype none

interface ccg_csr_if;
   logic valid;
   logic ready;
   logic [ccg_pkg::CSR_IDX_W-1:0] index;
   logic [ccg_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/coherence_candidate_generator.sv =====
// Top level of the coherence candidate generator: sequencer, datapath and checks.
//
// The req channel carries one item per transfer. A write (opcode 0) stores map_value
// at row*width+col of the target map if row and col lie inside it and gives no
// response; it passes through decode, address and memory write steps before the next
// item can be taken. A query (opcode 1) produces twelve rsp transfers, one per causal
// neighbor slot, the last one flagged by is_last. A query first reduces row and col
// together with an 8-step restoring modulo unit, then each slot runs through wrap,
// address multiply, map RAM read, candidate add and emit. The map RAM has one read
// and one write port, and each slot reads it once.
// The csr channel is always ready and writes target_width, target_height,
// source_width and source_limit at indexes 0 to 3; write it only while idle.
// After reset the sequencer clears all MAX_WIDTH*MAX_HEIGHT map entries (65536 by
// default) to unassigned, one entry per cycle; req.ready stays low meanwhile.
// Responses sit in an output register; while it is full and rsp.ready is low, the
// sequencer holds at its emit step. The last response of a query may still wait in
// that register while the next item is taken.
`default_nettype none

module coherence_candidate_generator #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256
) (
   input wire logic clock,
   input wire logic reset,
   ccg_req_if.sink req,
   ccg_rsp_if.source rsp,
   ccg_csr_if.sink csr
);

   ccg_pkg::ctrl_type ctrl;
   ccg_pkg::stat_type stat;

   ccg_seq u_seq (
      .clock(clock),
      .reset(reset),
      .stat(stat),
      .ctrl(ctrl)
   );

   ccg_dp #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .ctrl(ctrl),
      .stat(stat),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.cmd == ccg_pkg::CMD_CLEAR |-> !req.ready && !rsp.valid)
      else $error("item accepted or response shown during map clear");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ({1'b0, rsp.valid_count} <= {1'b0, rsp.neighbor_slot} + 5'd1))
      else $error("valid count exceeds slots seen");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.candidate_valid |-> rsp.candidate_index == '0)
      else $error("invalid candidate carries a nonzero index");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.is_last |=> !req.ready || !rsp.valid)
      else $error("response pending while a new item is taken");

endmodule

`default_nettype wire

// ===== design/ccg_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ccg_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 65536
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/ccg_seq.sv =====
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module ccg_seq (
   input wire logic clock,
   input wire logic reset,
   input wire ccg_pkg::stat_type stat,
   output ccg_pkg::ctrl_type ctrl
);

   ccg_pkg::upc_type upc_ff;
   ccg_pkg::upc_type upc_in;
   ccg_pkg::ctrl_type cw;
   logic jump;

   always_comb begin
      cw = ccg_pkg::ucode(upc_ff);
      unique case (cw.cond)
         ccg_pkg::COND_NONE: jump = 1'b0;
         ccg_pkg::COND_ALWAYS: jump = 1'b1;
         ccg_pkg::COND_NO_REQ: jump = !stat.req_valid;
         ccg_pkg::COND_IS_WRITE: jump = stat.is_write;
         ccg_pkg::COND_BITS_LEFT: jump = stat.bits_left;
         ccg_pkg::COND_OUT_BUSY: jump = stat.out_busy;
         ccg_pkg::COND_SLOT_MORE: jump = stat.slot_more;
         ccg_pkg::COND_CLR_MORE: jump = stat.clr_more;
      endcase
      upc_in = jump ? cw.target : upc_ff + ccg_pkg::UPC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ccg_pkg::S_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl = cw;

endmodule

`default_nettype wire

// ===== design/ccg_dp.sv =====
// Datapath: configuration registers, modulo unit, neighbor address, map RAM and output register.
`default_nettype none

module ccg_dp #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256
) (
   input wire logic clock,
   input wire logic reset,
   input wire ccg_pkg::ctrl_type ctrl,
   output ccg_pkg::stat_type stat,
   ccg_req_if.sink req,
   ccg_rsp_if.source rsp,
   ccg_csr_if.sink csr
);

   localparam int DW = ccg_pkg::DIM_W;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam int CLAMP_W = (MAX_WIDTH > ccg_pkg::DIM_MAX) ? ccg_pkg::DIM_MAX : MAX_WIDTH;
   localparam int CLAMP_H = (MAX_HEIGHT > ccg_pkg::DIM_MAX) ? ccg_pkg::DIM_MAX : MAX_HEIGHT;
   localparam int LW = 2 * DW + 1;
   localparam int SW = 19;

   logic [DW-1:0] cfg_tw_ff, cfg_th_ff, cfg_sw_ff;
   logic [ccg_pkg::LIMIT_W-1:0] cfg_lim_ff;

   logic op_ff, op_in;
   logic [ccg_pkg::ROW_W-1:0] row_ff, row_in;
   logic [ccg_pkg::COL_W-1:0] col_ff, col_in;
   logic [ccg_pkg::MAP_W-1:0] map_ff, map_in;
   logic [DW-1:0] rr_ff, rr_in, cc_ff, cc_in;
   logic [ccg_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [ccg_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [ccg_pkg::SLOT_W-1:0] count_ff, count_in;
   logic [DW-1:0] nr_ff, nr_in, nc_ff, nc_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic wr_ok_ff, wr_ok_in;
   logic cand_valid_ff, cand_valid_in;
   logic [ccg_pkg::IDX_W-1:0] cand_idx_ff, cand_idx_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_cvalid_ff, rsp_cvalid_in;
   logic [ccg_pkg::IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [ccg_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic rsp_last_ff, rsp_last_in;
   logic [ccg_pkg::SLOT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [DW-1:0] w_eff, h_eff, sw_eff;
   logic [ccg_pkg::LIMIT_W-1:0] lim_eff;
   logic [1:0] rows_up;
   logic signed [2:0] col_off;
   logic [DW:0] rrow_t, rcol_t;
   logic signed [10:0] tr0, tr1, tr2, tc0, tc1, tc2, tc3, tc4, h_s, w_s;
   logic [DW-1:0] mr, mc;
   logic [LW-1:0] lin;
   logic [10:0] radd;
   logic signed [SW-1:0] idx, lim_s;
   logic cand_ok;
   logic out_busy;
   logic accept;
   logic ram_wr_en;
   logic [ccg_pkg::MAP_W-1:0] ram_wr_data, ram_rd_data;

   always_comb begin
      if (cfg_tw_ff == '0) begin
         w_eff = DW'(1);
      end else if (32'(cfg_tw_ff) > CLAMP_W) begin
         w_eff = DW'(CLAMP_W);
      end else begin
         w_eff = cfg_tw_ff;
      end
      if (cfg_th_ff == '0) begin
         h_eff = DW'(1);
      end else if (32'(cfg_th_ff) > CLAMP_H) begin
         h_eff = DW'(CLAMP_H);
      end else begin
         h_eff = cfg_th_ff;
      end
      sw_eff = (cfg_sw_ff == '0) ? DW'(1) : cfg_sw_ff;
      lim_eff = (cfg_lim_ff > ccg_pkg::LIMIT_MAX) ? ccg_pkg::LIMIT_MAX : cfg_lim_ff;
   end

   assign rows_up = ccg_pkg::slot_rows_up(slot_ff);
   assign col_off = ccg_pkg::slot_col_off(slot_ff);
   assign out_busy = rsp_valid_ff && !rsp.ready;
   assign accept = (ctrl.cmd == ccg_pkg::CMD_ACCEPT) && req.valid;

   // One restoring step of row % height and col % width.
   always_comb begin
      rrow_t = {rr_ff, row_ff[ccg_pkg::ROW_W-1]};
      if (rrow_t >= {1'b0, h_eff}) begin
         rrow_t = rrow_t - {1'b0, h_eff};
      end
      rcol_t = {cc_ff, col_ff[ccg_pkg::COL_W-1]};
      if (rcol_t >= {1'b0, w_eff}) begin
         rcol_t = rcol_t - {1'b0, w_eff};
      end
   end

   // Toroidal wrap of the neighbor coordinates.
   always_comb begin
      h_s = signed'({2'b00, h_eff});
      w_s = signed'({2'b00, w_eff});
      tr0 = signed'({2'b00, rr_ff}) - signed'({9'd0, rows_up});
      tr1 = (tr0 < 0) ? tr0 + h_s : tr0;
      tr2 = (tr1 < 0) ? tr1 + h_s : tr1;
      tc0 = signed'({2'b00, cc_ff}) + 11'(col_off);
      tc1 = (tc0 < 0) ? tc0 + w_s : tc0;
      tc2 = (tc1 < 0) ? tc1 + w_s : tc1;
      tc3 = (tc2 >= w_s) ? tc2 - w_s : tc2;
      tc4 = (tc3 >= w_s) ? tc3 - w_s : tc3;
   end

   always_comb begin
      if (op_ff == ccg_pkg::OP_WRITE) begin
         mr = DW'(row_ff);
         mc = DW'(col_ff);
      end else begin
         mr = nr_ff;
         mc = nc_ff;
      end
      lin = LW'(mr * w_eff) + LW'(mc);
   end

   always_comb begin
      unique case (rows_up)
         2'd2: radd = {1'b0, sw_eff, 1'b0};
         2'd1: radd = {2'b00, sw_eff};
         default: radd = '0;
      endcase
      idx = signed'({3'b000, ram_rd_data[ccg_pkg::IDX_W-1:0]}) + signed'({8'd0, radd})
         - SW'(col_off);
      lim_s = signed'({2'b00, lim_eff});
      cand_ok = !ram_rd_data[ccg_pkg::MAP_W-1] && !idx[SW-1] && (idx < lim_s);
   end

   always_comb begin
      op_in = op_ff;
      row_in = row_ff;
      col_in = col_ff;
      map_in = map_ff;
      rr_in = rr_ff;
      cc_in = cc_ff;
      bit_cnt_in = bit_cnt_ff;
      slot_in = slot_ff;
      count_in = count_ff;
      nr_in = nr_ff;
      nc_in = nc_ff;
      addr_in = addr_ff;
      wr_ok_in = wr_ok_ff;
      cand_valid_in = cand_valid_ff;
      cand_idx_in = cand_idx_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_last_in = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      unique case (ctrl.cmd)
         ccg_pkg::CMD_CLEAR: begin
            addr_in = addr_ff + AW'(1);
         end
         ccg_pkg::CMD_ACCEPT: begin
            if (accept) begin
               op_in = req.opcode;
               row_in = req.row;
               col_in = req.col;
               map_in = req.map_value;
               rr_in = '0;
               cc_in = '0;
               bit_cnt_in = '0;
               slot_in = '0;
               count_in = '0;
            end
         end
         ccg_pkg::CMD_MOD_STEP: begin
            rr_in = rrow_t[DW-1:0];
            cc_in = rcol_t[DW-1:0];
            row_in = row_ff << 1;
            col_in = col_ff << 1;
            bit_cnt_in = bit_cnt_ff + ccg_pkg::BIT_CNT_W'(1);
         end
         ccg_pkg::CMD_NBR: begin
            nr_in = tr2[DW-1:0];
            nc_in = tc4[DW-1:0];
         end
         ccg_pkg::CMD_ADDR: begin
            addr_in = AW'(lin);
            wr_ok_in = ({1'b0, row_ff} < h_eff) && ({1'b0, col_ff} < w_eff);
         end
         ccg_pkg::CMD_CAND: begin
            cand_valid_in = cand_ok;
            cand_idx_in = cand_ok ? idx[ccg_pkg::IDX_W-1:0] : '0;
         end
         ccg_pkg::CMD_EMIT: begin
            if (!out_busy) begin
               count_in = count_ff + ccg_pkg::SLOT_W'(cand_valid_ff);
               rsp_valid_in = 1'b1;
               rsp_cvalid_in = cand_valid_ff;
               rsp_index_in = cand_idx_ff;
               rsp_slot_in = slot_ff;
               rsp_last_in = (slot_ff == ccg_pkg::LAST_SLOT);
               rsp_count_in = count_ff + ccg_pkg::SLOT_W'(cand_valid_ff);
            end
         end
         ccg_pkg::CMD_SLOT_INC: begin
            slot_in = slot_ff + ccg_pkg::SLOT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_tw_ff <= DW'(256);
         cfg_th_ff <= DW'(256);
         cfg_sw_ff <= DW'(256);
         cfg_lim_ff <= ccg_pkg::LIMIT_MAX;
         addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff <= ccg_pkg::OP_WRITE;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               ccg_pkg::REG_TARGET_WIDTH: cfg_tw_ff <= csr.data[DW-1:0];
               ccg_pkg::REG_TARGET_HEIGHT: cfg_th_ff <= csr.data[DW-1:0];
               ccg_pkg::REG_SOURCE_WIDTH: cfg_sw_ff <= csr.data[DW-1:0];
               ccg_pkg::REG_SOURCE_LIMIT: cfg_lim_ff <= csr.data;
            endcase
         end
         addr_ff <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      map_ff <= map_in;
      rr_ff <= rr_in;
      cc_ff <= cc_in;
      bit_cnt_ff <= bit_cnt_in;
      slot_ff <= slot_in;
      count_ff <= count_in;
      nr_ff <= nr_in;
      nc_ff <= nc_in;
      wr_ok_ff <= wr_ok_in;
      cand_valid_ff <= cand_valid_in;
      cand_idx_ff <= cand_idx_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_index_ff <= rsp_index_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign ram_wr_en = (ctrl.cmd == ccg_pkg::CMD_CLEAR)
      || ((ctrl.cmd == ccg_pkg::CMD_WRITE) && wr_ok_ff);
   assign ram_wr_data = (ctrl.cmd == ccg_pkg::CMD_CLEAR) ? '1 : map_ff;

   ccg_ram #(
      .WIDTH(ccg_pkg::MAP_W),
      .DEPTH(DEPTH)
   ) u_map (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(addr_ff),
      .wr_data(ram_wr_data),
      .rd_en(ctrl.cmd == ccg_pkg::CMD_READ),
      .rd_addr(addr_ff),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      stat.req_valid = req.valid;
      stat.is_write = (op_ff == ccg_pkg::OP_WRITE);
      stat.bits_left = (bit_cnt_ff != ccg_pkg::BIT_CNT_W'(ccg_pkg::ROW_W - 1));
      stat.out_busy = out_busy;
      stat.slot_more = (slot_ff != ccg_pkg::LAST_SLOT);
      stat.clr_more = (addr_ff != AW'(DEPTH - 1));
   end

   assign req.ready = (ctrl.cmd == ccg_pkg::CMD_ACCEPT);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.candidate_valid = rsp_cvalid_ff;
   assign rsp.candidate_index = rsp_index_ff;
   assign rsp.neighbor_slot = rsp_slot_ff;
   assign rsp.is_last = rsp_last_ff;
   assign rsp.valid_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the coherence candidate generator: map writes, queries, settings.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_DEPTH = 65536;
   localparam int GRID_MAX = 256;
   localparam int ITEM_GOAL = 450;
   localparam int PHASE_ITEMS = 75;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int WRITE_SETTLE = 16;
   localparam int END_CYCLES = 100;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic op;
      logic [ccg_pkg::ROW_W-1:0] row;
      logic [ccg_pkg::COL_W-1:0] col;
      logic signed [ccg_pkg::MAP_W-1:0] value;
   } map_op_type;

   typedef struct packed {
      logic cand_valid;
      logic [ccg_pkg::IDX_W-1:0] index;
      logic [ccg_pkg::SLOT_W-1:0] slot;
      logic last;
      logic [ccg_pkg::SLOT_W-1:0] count;
   } candidate_type;

   logic clock = 1'b0;
   logic reset;

   ccg_req_if req_bus();
   ccg_rsp_if rsp_bus();
   ccg_csr_if csr_bus();

   coherence_candidate_generator u_top (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus),
      .csr(csr_bus)
   );

   logic signed [ccg_pkg::MAP_W-1:0] shadow_map [0:MAP_DEPTH-1];
   logic [ccg_pkg::DIM_W-1:0] cfg_target_width;
   logic [ccg_pkg::DIM_W-1:0] cfg_target_height;
   logic [ccg_pkg::DIM_W-1:0] cfg_source_width;
   logic [ccg_pkg::LIMIT_W-1:0] cfg_source_limit;
   candidate_type expected_candidates [$];

   int fail_count = 0;
   int stored_writes = 0;
   int ignored_writes = 0;
   int query_count = 0;
   int csr_writes = 0;
   int results_checked = 0;
   int valid_seen = 0;
   int burst_left = 1;
   int stall_cycles = 0;
   logic [31:0] ready_pattern;

   always #6 clock = ~clock;

   function automatic int map_width();
      if (cfg_target_width == '0) return 1;
      if (cfg_target_width > GRID_MAX) return GRID_MAX;
      return int'(cfg_target_width);
   endfunction

   function automatic int map_height();
      if (cfg_target_height == '0) return 1;
      if (cfg_target_height > GRID_MAX) return GRID_MAX;
      return int'(cfg_target_height);
   endfunction

   function automatic int slot_rows_above(input int slot);
      return (slot < 5) ? 2 : ((slot < 10) ? 1 : 0);
   endfunction

   function automatic int slot_col_shift(input int slot);
      return (slot < 10) ? (slot % 5) - 2 : slot - 12;
   endfunction

   function automatic void neighbor_cell(input int r, input int c, input int slot,
                                         output int nr, output int nc);
      int h;
      int w;
      h = map_height();
      w = map_width();
      nr = (r + 2 * h - slot_rows_above(slot)) % h;
      nc = (c + 2 * w + slot_col_shift(slot)) % w;
   endfunction

   function automatic map_op_type make_op(input logic op, input int row, input int col,
                                          input logic signed [ccg_pkg::MAP_W-1:0] value);
      map_op_type item;
      item.op = op;
      item.row = ccg_pkg::ROW_W'(row);
      item.col = ccg_pkg::COL_W'(col);
      item.value = value;
      return item;
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("Mismatch %0d at %0t: %s", fail_count, $time, what);
      end
   endfunction

   // Mirrors one accepted item: a write inside the map updates it, a query queues its twelve candidates.
   function automatic void predict_candidates(input map_op_type item);
      int h;
      int w;
      int sw;
      int rr;
      int cc;
      int nr;
      int nc;
      int count;
      longint stored;
      longint idx;
      longint limit;
      candidate_type cand;
      h = map_height();
      w = map_width();
      if (item.op == ccg_pkg::OP_WRITE) begin
         if (int'(item.row) < h && int'(item.col) < w) begin
            shadow_map[int'(item.row) * w + int'(item.col)] = item.value;
            stored_writes++;
         end else begin
            ignored_writes++;
         end
      end else begin
         query_count++;
         sw = (cfg_source_width == '0) ? 1 : int'(cfg_source_width);
         limit = (cfg_source_limit > ccg_pkg::LIMIT_MAX) ? longint'(ccg_pkg::LIMIT_MAX)
                                                         : longint'(cfg_source_limit);
         rr = int'(item.row) % h;
         cc = int'(item.col) % w;
         count = 0;
         for (int slot = 0; slot < ccg_pkg::NEIGHBORS; slot++) begin
            neighbor_cell(rr, cc, slot, nr, nc);
            stored = shadow_map[nr * w + nc];
            cand = '0;
            cand.slot = ccg_pkg::SLOT_W'(slot);
            cand.last = (slot == ccg_pkg::NEIGHBORS - 1);
            if (stored >= 0) begin
               idx = stored + longint'(slot_rows_above(slot)) * sw - slot_col_shift(slot);
               if (idx >= 0 && idx < limit) begin
                  cand.cand_valid = 1'b1;
                  cand.index = ccg_pkg::IDX_W'(idx);
                  count++;
               end
            end
            cand.count = ccg_pkg::SLOT_W'(count);
            expected_candidates.push_back(cand);
         end
      end
   endfunction

   task automatic send_item(input map_op_type item);
      @(negedge clock);
      req_bus.opcode = item.op;
      req_bus.row = item.row;
      req_bus.col = item.col;
      req_bus.map_value = item.value;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_candidates(item);
      burst_left--;
      if (burst_left <= 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      end
   endtask

   task automatic write_register(input logic [ccg_pkg::CSR_IDX_W-1:0] reg_index,
                                 input logic [ccg_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.index = reg_index;
      csr_bus.data = data;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (reg_index)
         ccg_pkg::REG_TARGET_WIDTH: cfg_target_width = data[ccg_pkg::DIM_W-1:0];
         ccg_pkg::REG_TARGET_HEIGHT: cfg_target_height = data[ccg_pkg::DIM_W-1:0];
         ccg_pkg::REG_SOURCE_WIDTH: cfg_source_width = data[ccg_pkg::DIM_W-1:0];
         ccg_pkg::REG_SOURCE_LIMIT: cfg_source_limit = data[ccg_pkg::LIMIT_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_config(input logic [ccg_pkg::CSR_DATA_W-1:0] tw,
                             input logic [ccg_pkg::CSR_DATA_W-1:0] th,
                             input logic [ccg_pkg::CSR_DATA_W-1:0] sw,
                             input logic [ccg_pkg::CSR_DATA_W-1:0] lim);
      write_register(ccg_pkg::REG_TARGET_WIDTH, tw);
      write_register(ccg_pkg::REG_TARGET_HEIGHT, th);
      write_register(ccg_pkg::REG_SOURCE_WIDTH, sw);
      write_register(ccg_pkg::REG_SOURCE_LIMIT, lim);
   endtask

   // A map write gives no transfer, so the block may still be busy with one after the last result.
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_candidates.size() != 0) @(posedge clock);
      repeat (WRITE_SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [ccg_pkg::MAP_W-1:0] pick_map_value();
      case ($urandom_range(0, 9))
         0: return -17'sd1;
         1: return ccg_pkg::MAP_W'($urandom) | 17'h10000;
         2: return ccg_pkg::MAP_W'($urandom_range(0, 3));
         3: return ccg_pkg::MAP_W'($urandom_range(65000, 65535));
         4: return ccg_pkg::MAP_W'($urandom_range(0, 700));
         default: return ccg_pkg::MAP_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [ccg_pkg::CSR_DATA_W-1:0] pick_dim_data();
      logic [ccg_pkg::DIM_W-1:0] dim;
      case ($urandom_range(0, 7))
         0: dim = '0;
         1: dim = ccg_pkg::DIM_W'($urandom_range(GRID_MAX + 1, ccg_pkg::DIM_MAX));
         2, 3: dim = ccg_pkg::DIM_W'($urandom_range(1, 4));
         4, 5: dim = ccg_pkg::DIM_W'($urandom_range(5, 16));
         default: dim = ccg_pkg::DIM_W'($urandom_range(17, GRID_MAX));
      endcase
      return ($urandom_range(0, 3) == 0) ? {8'($urandom), dim} : {8'd0, dim};
   endfunction

   function automatic logic [ccg_pkg::CSR_DATA_W-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0: return ccg_pkg::CSR_DATA_W'($urandom_range(0, 700));
         1: return ccg_pkg::CSR_DATA_W'($urandom_range(65537, 131071));
         2: return ccg_pkg::CSR_DATA_W'($urandom_range(0, 131071));
         default: return ccg_pkg::CSR_DATA_W'(ccg_pkg::LIMIT_MAX);
      endcase
   endfunction

   task automatic choose_setting(input int phase);
      logic [ccg_pkg::CSR_DATA_W-1:0] sw_data;
      if (phase == 0) begin
         set_config(17'd256, 17'd256, 17'd256, ccg_pkg::CSR_DATA_W'(ccg_pkg::LIMIT_MAX));
      end else begin
         sw_data = ($urandom_range(0, 3) == 0)
                      ? ccg_pkg::CSR_DATA_W'($urandom)
                      : ccg_pkg::CSR_DATA_W'($urandom_range(0, ccg_pkg::DIM_MAX));
         set_config(pick_dim_data(), pick_dim_data(), sw_data, pick_limit());
      end
   endtask

   task automatic test_cleared_map();
      send_item(make_op(ccg_pkg::OP_QUERY, 0, 0, '0));
      send_item(make_op(ccg_pkg::OP_QUERY, 255, 255, '0));
      send_item(make_op(ccg_pkg::OP_QUERY, 128, 7, '0));
      settle_block();
   endtask

   // Every neighbor of the corner pixel wraps across at least one map edge.
   task automatic test_wrapped_neighbors();
      send_item(make_op(ccg_pkg::OP_WRITE, 254, 254, 17'sd0));
      send_item(make_op(ccg_pkg::OP_WRITE, 254, 255, 17'sd65535));
      send_item(make_op(ccg_pkg::OP_WRITE, 254, 0, -17'sd1));
      send_item(make_op(ccg_pkg::OP_WRITE, 254, 1, 17'sh10000));
      send_item(make_op(ccg_pkg::OP_WRITE, 254, 2, 17'sd1));
      send_item(make_op(ccg_pkg::OP_WRITE, 255, 254, 17'sd12345));
      send_item(make_op(ccg_pkg::OP_WRITE, 255, 0, 17'sd65023));
      send_item(make_op(ccg_pkg::OP_WRITE, 0, 254, 17'sd65534));
      send_item(make_op(ccg_pkg::OP_WRITE, 0, 255, 17'sd65533));
      send_item(make_op(ccg_pkg::OP_QUERY, 0, 0, 17'sh1FFFF));
      settle_block();
   endtask

   task automatic test_dimension_extremes();
      set_config(17'd0, 17'd0, 17'd0, 17'h1FFFF);
      send_item(make_op(ccg_pkg::OP_WRITE, 3, 3, 17'sd7));
      send_item(make_op(ccg_pkg::OP_WRITE, 0, 0, 17'sd5));
      send_item(make_op(ccg_pkg::OP_QUERY, 200, 77, '0));
      settle_block();
      set_config(17'd511, 17'd300, 17'd511, 17'd0);
      send_item(make_op(ccg_pkg::OP_QUERY, 255, 0, '0));
      settle_block();
      // The upper bits of the width data are dropped, leaving a width of four.
      set_config(17'h1FE04, 17'd4, 17'd1, 17'd65536);
      send_item(make_op(ccg_pkg::OP_WRITE, 2, 3, 17'sd0));
      send_item(make_op(ccg_pkg::OP_WRITE, 4, 0, 17'sd9));
      send_item(make_op(ccg_pkg::OP_WRITE, 1, 4, 17'sd9));
      send_item(make_op(ccg_pkg::OP_QUERY, 3, 1, '0));
      send_item(make_op(ccg_pkg::OP_QUERY, 7, 5, '0));
      settle_block();
   endtask

   // Most of the traffic fills part of a pixel's neighborhood and then queries that pixel.
   task automatic test_random_phases();
      int phase;
      int phase_items;
      int goal;
      int h;
      int w;
      int r;
      int c;
      int nr;
      int nc;
      int picks;
      int qrow;
      int qcol;
      phase = 0;
      goal = stored_writes + query_count + ITEM_GOAL;
      while (stored_writes + query_count < goal) begin
         settle_block();
         choose_setting(phase);
         h = map_height();
         w = map_width();
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && stored_writes + query_count < goal) begin
            case ($urandom_range(0, 9))
               7: begin
                  send_item(make_op(ccg_pkg::OP_WRITE, $urandom_range(0, 255),
                                    $urandom_range(0, 255), pick_map_value()));
                  phase_items++;
               end
               8: begin
                  send_item(make_op(ccg_pkg::OP_QUERY, $urandom_range(0, 255),
                                    $urandom_range(0, 255), ccg_pkg::MAP_W'($urandom)));
                  phase_items++;
               end
               9: begin
                  send_item(make_op(ccg_pkg::OP_WRITE, $urandom_range(0, h - 1),
                                    $urandom_range(0, w - 1), -17'sd1));
                  phase_items++;
               end
               default: begin
                  r = $urandom_range(0, h - 1);
                  c = $urandom_range(0, w - 1);
                  picks = $urandom_range(1, ccg_pkg::NEIGHBORS);
                  for (int slot = 0; slot < ccg_pkg::NEIGHBORS; slot++) begin
                     if ($urandom_range(1, ccg_pkg::NEIGHBORS) <= picks) begin
                        neighbor_cell(r, c, slot, nr, nc);
                        send_item(make_op(ccg_pkg::OP_WRITE, nr, nc, pick_map_value()));
                        phase_items++;
                     end
                  end
                  qrow = r;
                  qcol = c;
                  if ($urandom_range(0, 3) == 0) begin
                     qrow = r + h * $urandom_range(0, (GRID_MAX - 1 - r) / h);
                     qcol = c + w * $urandom_range(0, (GRID_MAX - 1 - c) / w);
                  end
                  send_item(make_op(ccg_pkg::OP_QUERY, qrow, qcol,
                                    ccg_pkg::MAP_W'($urandom)));
                  phase_items++;
               end
            endcase
         end
         phase++;
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         case ($urandom_range(0, 3))
            0: ready_pattern = '1;
            1: ready_pattern = $urandom;
            2: ready_pattern = $urandom | $urandom;
            default: ready_pattern = $urandom & $urandom;
         endcase
         repeat (64) begin
            @(negedge clock);
            rsp_bus.ready = ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
         end
      end
   end

   always @(posedge clock) begin
      candidate_type seen;
      candidate_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.cand_valid = rsp_bus.candidate_valid;
         seen.index = rsp_bus.candidate_index;
         seen.slot = rsp_bus.neighbor_slot;
         seen.last = rsp_bus.is_last;
         seen.count = rsp_bus.valid_count;
         results_checked++;
         if (seen.cand_valid) valid_seen++;
         if (expected_candidates.size() == 0) begin
            note_failure($sformatf("unexpected transfer: valid=%0b index=%0d slot=%0d",
                                   seen.cand_valid, seen.index, seen.slot));
         end else begin
            want = expected_candidates.pop_front();
            if (seen !== want) begin
               note_failure({$sformatf("expected valid=%0b index=%0d slot=%0d last=%0b count=%0d",
                                       want.cand_valid, want.index, want.slot, want.last,
                                       want.count),
                             $sformatf(", got valid=%0b index=%0d slot=%0d last=%0b count=%0d",
                                       seen.cand_valid, seen.index, seen.slot, seen.last,
                                       seen.count)});
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer, %0d candidates pending.",
                  stall_cycles, expected_candidates.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = ccg_pkg::OP_WRITE;
      req_bus.row = '0;
      req_bus.col = '0;
      req_bus.map_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = ccg_pkg::REG_TARGET_WIDTH;
      csr_bus.data = '0;
      cfg_target_width = 9'd256;
      cfg_target_height = 9'd256;
      cfg_source_width = 9'd256;
      cfg_source_limit = ccg_pkg::LIMIT_MAX;
      for (int i = 0; i < MAP_DEPTH; i++) shadow_map[i] = -17'sd1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_map();
      test_wrapped_neighbors();
      test_dimension_extremes();
      test_random_phases();

      settle_block();
      repeat (END_CYCLES) @(posedge clock);
      $display("Covered %0d stored and %0d out-of-map writes, %0d queries, %0d register writes.",
               stored_writes, ignored_writes, query_count, csr_writes);
      $display("Checked %0d candidate transfers, %0d of them valid, with %0d failures.",
               results_checked, valid_seen, fail_count);
      if (fail_count == 0 && expected_candidates.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
